// ===== rtl/core/gmps_pkg.sv =====
// Shared widths, register indexes and defaults for the grid minimum path sum block.
`timescale 1ns / 1ps

package gmps_pkg;

  // Payload widths
  localparam int unsigned CostW   = 16;
  localparam int unsigned PathW   = 32;

  // Configuration port widths
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CfgIdxW  = 2;

  // Grid limits
  localparam int unsigned MaxColumnsDef = 2048;
  localparam int unsigned RowLimit      = 2048;
  localparam int unsigned RowIdxW       = $clog2(RowLimit);

  // Register reset values
  localparam logic [CfgDataW-1:0] GridColumnsRst = CfgDataW'(2048);
  localparam logic [CfgDataW-1:0] GridRowsRst    = CfgDataW'(2048);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgGridColumns = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGridRows    = CfgIdxW'(1);

  typedef logic [CostW-1:0] cost_t;
  typedef logic [PathW-1:0] path_t;

  // Add a cell cost to a path cost, clamping at the largest path cost
  function automatic path_t sat_add(path_t base, cost_t cost);
    logic [PathW:0] sum;
    sum = {1'b0, base} + (PathW + 1)'(cost);
    return sum[PathW] ? {PathW{1'b1}} : sum[PathW-1:0];
  endfunction

endpackage

// ===== rtl/core/grid_min_path_sum_top.sv =====
// Grid minimum path sum: row-store memory, read-modify-write stage and output register.
`timescale 1ns / 1ps

// Streams grid cell costs in row-major order and returns, for every cell, the least cost
// of a right/down path from the top-left cell, saturating at 0xFFFFFFFF. One cell is
// taken every cycle unless the input is stalled; each result passes the compute stage
// and is then held in the output register; while it waits there, one more request can
// enter the compute stage. The rate is set by the row memory: one read at request time
// and one write of the finished sum per cell, with a bypass when a one-column grid reads
// the entry that is being written. The row memory needs no clearing pass; every entry
// is written by the first row of a grid before it is read. Writing either size register
// restarts at the top-left cell and must only be done while no request is in flight.
module grid_min_path_sum_top #(
  parameter int unsigned MAX_COLUMNS = gmps_pkg::MaxColumnsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Cell requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gmps_pkg::CostW-1:0]     cell_cost_i,
  // Results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gmps_pkg::PathW-1:0]     path_cost_o,
  output logic                           last_cell_o,
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gmps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gmps_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gmps_pkg::*;

  localparam int unsigned ColIdxW = $clog2(MAX_COLUMNS);
  localparam int unsigned CmpW    = ((ColIdxW > CfgDataW) ? ColIdxW : CfgDataW) + 1;
  localparam int unsigned RowCmpW = ((RowIdxW > CfgDataW) ? RowIdxW : CfgDataW) + 1;

  // Configuration registers
  logic [CfgDataW-1:0] grid_columns_q, grid_rows_q;
  logic                cfg_write;
  logic                cfg_restart;

  // Position counters
  logic [ColIdxW-1:0]  col_idx_q, col_idx_d;
  logic [RowIdxW-1:0]  row_idx_q, row_idx_d;
  logic [ColIdxW-1:0]  cols_last;
  logic [RowIdxW-1:0]  rows_last;
  logic [CmpW-1:0]     cols_ext;
  logic [RowCmpW-1:0]  rows_ext;

  // Row memory
  path_t               row_mem [MAX_COLUMNS];
  path_t               rdata_q;

  // Compute stage
  logic                s1_valid_q;
  logic [ColIdxW-1:0]  s1_col_q;
  logic                s1_row0_q, s1_col0_q, s1_last_q;
  cost_t               s1_cost_q;
  logic                fwd_q;
  path_t               fwd_val_q;
  path_t               left_q;
  path_t               above, base, sum;
  logic                s1_move, in_accept;

  // Output register
  logic                out_valid_q;
  path_t               path_cost_q;
  logic                last_cell_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  // Only a write to a size register restarts the grid
  assign cfg_restart = cfg_write && (cfg_index_i inside {CfgGridColumns, CfgGridRows});

  // Hold the size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= GridColumnsRst;
      grid_rows_q    <= GridRowsRst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgGridColumns: grid_columns_q <= cfg_data_i;
        CfgGridRows:    grid_rows_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to their legal ranges and take the last index
  always_comb begin
    cols_ext = CmpW'(grid_columns_q);
    if (cols_ext == '0) begin
      cols_ext = CmpW'(1);
    end
    if (cols_ext > CmpW'(MAX_COLUMNS)) begin
      cols_ext = CmpW'(MAX_COLUMNS);
    end
    rows_ext = RowCmpW'(grid_rows_q);
    if (rows_ext == '0) begin
      rows_ext = RowCmpW'(1);
    end
    if (rows_ext > RowCmpW'(RowLimit)) begin
      rows_ext = RowCmpW'(RowLimit);
    end
  end

  assign cols_last = ColIdxW'(cols_ext - CmpW'(1));
  assign rows_last = RowIdxW'(rows_ext - RowCmpW'(1));

  // Handshake: the compute stage drains into an empty or departing output register
  assign s1_move     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Advance the position over the grid
  always_comb begin
    col_idx_d = col_idx_q;
    row_idx_d = row_idx_q;
    if (in_accept) begin
      if (col_idx_q == cols_last) begin
        col_idx_d = '0;
        row_idx_d = (row_idx_q == rows_last) ? '0 : row_idx_q + RowIdxW'(1);
      end else begin
        col_idx_d = col_idx_q + ColIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_idx_q <= '0;
      row_idx_q <= '0;
    end else if (cfg_restart) begin
      col_idx_q <= '0;
      row_idx_q <= '0;
    end else begin
      col_idx_q <= col_idx_d;
      row_idx_q <= row_idx_d;
    end
  end

  // Row memory: read above entry on request, write finished sum when the stage drains
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      row_mem[s1_col_q] <= sum;
    end
    if (in_accept) begin
      rdata_q <= row_mem[col_idx_q];
    end
  end

  // Compute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      left_q     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_move && (s1_col_q == col_idx_q);
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (cfg_restart) begin
        left_q <= '0;
      end else if (s1_move) begin
        left_q <= sum;
      end
    end
  end

  // Compute stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q  <= col_idx_q;
      s1_row0_q <= (row_idx_q == '0);
      s1_col0_q <= (col_idx_q == '0);
      s1_last_q <= (row_idx_q == rows_last) && (col_idx_q == cols_last);
      s1_cost_q <= cell_cost_i;
      fwd_val_q <= sum;
    end
  end

  // Pick the base cost and add the cell cost
  assign above = fwd_q ? fwd_val_q : rdata_q;

  always_comb begin
    if (s1_row0_q && s1_col0_q) begin
      base = '0;
    end else if (s1_row0_q) begin
      base = left_q;
    end else if (s1_col0_q) begin
      base = above;
    end else begin
      base = (above < left_q) ? above : left_q;
    end
  end

  assign sum = sat_add(base, s1_cost_q);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      path_cost_q <= sum;
      last_cell_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_cost_o = path_cost_q;
  assign last_cell_o = last_cell_q;

`ifndef NO_ASSERTIONS
  // Every request lands in the compute stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted request did not reach the compute stage");

  // Bypass only happens on column zero, as on a one-column grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && fwd_q) |-> (s1_col_q == '0))
    else $error("row memory bypass on a column other than zero");

  // A blocked compute stage must stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while the compute stage is blocked");

  // Position stays inside the configured grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_accept) |-> (col_idx_q <= cols_last && row_idx_q <= rows_last))
    else $error("grid position out of range");
`endif

endmodule
